// ----- design/typed_command_frame_parser_defines.svh -----
// assertion macros shared by the frame parser rtl
`ifndef TYPED_COMMAND_FRAME_PARSER_DEFINES_SVH
`define TYPED_COMMAND_FRAME_PARSER_DEFINES_SVH

// same-cycle implication, sampled on clk, off while in reset
`define TCFP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while in reset
`define TCFP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/tcfp_pkg.sv -----
// ---------------------------------------------------------------------------
// tcfp_pkg
// Types, codes and fixed command tables for the typed command frame parser.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tcfp_pkg;

    // parser phase, one-hot
    typedef enum logic [7:0] {
        PH_CMD    = 8'b0000_0001,
        PH_HDR    = 8'b0000_0010,
        PH_TAG    = 8'b0000_0100,
        PH_SCALAR = 8'b0000_1000,
        PH_MODE   = 8'b0001_0000,
        PH_ELEM   = 8'b0010_0000,
        PH_ADDR   = 8'b0100_0000,
        PH_SKIP   = 8'b1000_0000
    } phase_t;

    // record kinds
    localparam logic [1:0] KIND_SCALAR = 2'd0;
    localparam logic [1:0] KIND_ELEM   = 2'd1;
    localparam logic [1:0] KIND_ADDR   = 2'd2;
    localparam logic [1:0] KIND_STATUS = 2'd3;

    // frame status codes
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_UNKNOWN = 3'd1;
    localparam logic [2:0] ST_NOREPLY = 3'd2;
    localparam logic [2:0] ST_COUNT   = 3'd3;
    localparam logic [2:0] ST_DECODE  = 3'd4;
    localparam logic [2:0] ST_SHORT   = 3'd5;

    // argument type codes
    localparam logic [3:0] TY_U8      = 4'd0;
    localparam logic [3:0] TY_U16     = 4'd1;
    localparam logic [3:0] TY_U32     = 4'd2;
    localparam logic [3:0] TY_U8_ARR  = 4'd3;
    localparam logic [3:0] TY_U16_ARR = 4'd4;
    localparam logic [3:0] TY_INT     = 4'd6;
    localparam logic [3:0] TY_MAX     = 4'd7;
    localparam logic [3:0] TY_NONE    = 4'd15;

    // command space
    localparam logic [7:0] CMD_NOREPLY = 8'd10;
    localparam logic [7:0] NUM_CMD     = 8'd10;
    localparam int         NUM_COLS    = 8;

    // mode byte fields
    localparam logic [7:0] MODE_ARRAY = 8'h80;
    localparam logic [7:0] MODE_LEN   = 8'h7F;

    // expected argument count per command
    localparam logic [4:0] ARG_COUNT [0:9] = '{
        5'd3, 5'd3, 5'd4, 5'd4, 5'd3, 5'd3, 5'd4, 5'd1, 5'd1, 5'd8
    };

    // expected argument type per command and position
    localparam logic [3:0] TYPE_TABLE [0:79] = '{
        4'd0, 4'd1, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0,
        4'd0, 4'd1, 4'd3, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0,
        4'd0, 4'd1, 4'd3, 4'd1, 4'd0, 4'd0, 4'd0, 4'd0,
        4'd0, 4'd1, 4'd1, 4'd3, 4'd0, 4'd0, 4'd0, 4'd0,
        4'd0, 4'd1, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0,
        4'd0, 4'd1, 4'd3, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0,
        4'd0, 4'd1, 4'd3, 4'd1, 4'd0, 4'd0, 4'd0, 4'd0,
        4'd3, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0,
        4'd4, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0,
        4'd6, 4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd7
    };

    // one result item
    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  cmd;
        logic [4:0]  arg_idx;
        logic [3:0]  arg_ty;
        logic [31:0] val;
        logic [6:0]  elem_idx;
        logic [2:0]  st;
        logic        is_last;
    } record_t;

    // element byte count of an array type
    function automatic logic [2:0] elem_bytes(input logic [3:0] ty);
        logic [2:0] sz;
        begin
            if (ty == TY_U8_ARR) begin
                sz = 3'd1;
            end else if (ty == TY_U16_ARR) begin
                sz = 3'd2;
            end else begin
                sz = 3'd4;
            end
            return sz;
        end
    endfunction

endpackage

`default_nettype wire

// ----- design/typed_command_frame_parser.sv -----
// ---------------------------------------------------------------------------
// typed_command_frame_parser
// Byte-wide parser for typed command frames: checks header and tags against
// a fixed command table and emits scalar, element, address and status items.
// ---------------------------------------------------------------------------
//
//  channel | handshake               | payload
//  --------+-------------------------+------------------------------------------
//  input   | item_valid / item_ready | data_byte, frame_end
//  output  | rec_valid / rec_ready   | record_kind, command_code, arg_index,
//          |                         | arg_type, value, element_index, status,
//          |                         | last
//
//  one input item per cycle while item_ready is high; parse state updates at the accepting edge
//  an item yields zero, one or two result items, written into a four-entry
//  result queue at the accepting edge; with an empty queue the first result is visible the cycle after acceptance
//  item_ready is high while the queue holds at most two items
//  a stalled output only blocks input once the queue reaches three items
//  reset returns to waiting for a command byte and empties the queue
//
`timescale 1ns / 1ps
`default_nettype none

`include "typed_command_frame_parser_defines.svh"

module typed_command_frame_parser #(
    parameter int MAX_ARGS = 8
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        item_valid,
    output logic             item_ready,
    input  wire logic [7:0]  data_byte,
    input  wire logic        frame_end,
    output logic             rec_valid,
    input  wire logic        rec_ready,
    output logic [1:0]       record_kind,
    output logic [7:0]       command_code,
    output logic [4:0]       arg_index,
    output logic [3:0]       arg_type,
    output logic [31:0]      value,
    output logic [6:0]       element_index,
    output logic [2:0]       status,
    output logic             last
);

    localparam int QDEPTH = 4;

    // parse state
    tcfp_pkg::phase_t phase_reg, phase_next;
    logic [7:0]  command_reg, command_next;
    logic [4:0]  args_exp_reg, args_exp_next;
    logic [4:0]  arg_cnt_reg, arg_cnt_next;
    logic [3:0]  exp_type_reg, exp_type_next;
    logic [2:0]  byte_cnt_reg, byte_cnt_next;
    logic [31:0] acc_reg, acc_next;
    logic [6:0]  array_len_reg, array_len_next;
    logic [6:0]  elem_cnt_reg, elem_cnt_next;
    logic [2:0]  err_reg, err_next;

    // step outputs
    logic                 data_v;
    tcfp_pkg::record_t    data_rec;
    logic                 stat_v;
    tcfp_pkg::record_t    stat_rec;
    logic                 adv_arg;
    logic [4:0]           arg_inc;
    logic [4:0]           hdr_cnt;
    logic [31:0]          acc_shift;
    logic [2:0]           byte_dec;
    logic [6:0]           elem_inc;
    logic [2:0]           stat_code;

    // result queue
    tcfp_pkg::record_t    queue_reg [0:QDEPTH-1];
    logic [1:0]           wr_ptr_reg, rd_ptr_reg;
    logic [2:0]           count_reg;
    logic                 item_fire;
    logic                 rec_fire;
    logic [1:0]           push_n;

    // table lookup of the expected type at one argument position
    function automatic logic [3:0] lookup_type(input logic [7:0] cmd, input logic [4:0] idx);
        logic [3:0] ty;
        logic [6:0] tidx;
        begin
            tidx = {cmd[3:0], idx[2:0]};
            if (cmd >= tcfp_pkg::NUM_CMD || int'(idx) >= tcfp_pkg::NUM_COLS
                || int'(idx) >= MAX_ARGS) begin
                ty = tcfp_pkg::TY_NONE;
            end else begin
                ty = tcfp_pkg::TYPE_TABLE[tidx];
            end
            return ty;
        end
    endfunction

    assign item_fire = item_valid && item_ready;
    assign rec_fire  = rec_valid && rec_ready;

    // one parse step for the offered byte
    always_comb
    begin
        phase_next     = phase_reg;
        command_next   = command_reg;
        args_exp_next  = args_exp_reg;
        arg_cnt_next   = arg_cnt_reg;
        exp_type_next  = exp_type_reg;
        byte_cnt_next  = byte_cnt_reg;
        acc_next       = acc_reg;
        array_len_next = array_len_reg;
        elem_cnt_next  = elem_cnt_reg;
        err_next       = err_reg;
        data_v         = 1'b0;
        adv_arg        = 1'b0;
        arg_inc        = arg_cnt_reg + 5'd1;
        hdr_cnt        = data_byte[7:3];
        acc_shift      = {acc_reg[23:0], data_byte};
        byte_dec       = byte_cnt_reg - 3'd1;
        elem_inc       = elem_cnt_reg + 7'd1;
        stat_code      = tcfp_pkg::ST_OK;

        data_rec          = '0;
        data_rec.cmd      = command_reg;
        data_rec.arg_idx  = arg_cnt_reg;
        data_rec.arg_ty   = exp_type_reg;
        data_rec.val      = acc_shift;

        case (phase_reg)
            tcfp_pkg::PH_CMD:
            begin
                args_exp_next  = '0;
                arg_cnt_next   = '0;
                exp_type_next  = '0;
                byte_cnt_next  = '0;
                acc_next       = '0;
                array_len_next = '0;
                elem_cnt_next  = '0;
                err_next       = tcfp_pkg::ST_OK;
                command_next   = data_byte;
                phase_next     = tcfp_pkg::PH_HDR;
            end
            tcfp_pkg::PH_HDR:
            begin
                if (command_reg > tcfp_pkg::CMD_NOREPLY) begin
                    err_next = tcfp_pkg::ST_UNKNOWN;
                end else if (command_reg == tcfp_pkg::CMD_NOREPLY) begin
                    err_next = tcfp_pkg::ST_NOREPLY;
                end else if (hdr_cnt != tcfp_pkg::ARG_COUNT[command_reg[3:0]]
                             || int'(hdr_cnt) > MAX_ARGS) begin
                    err_next = tcfp_pkg::ST_COUNT;
                end
                if (err_next != tcfp_pkg::ST_OK) begin
                    phase_next = tcfp_pkg::PH_SKIP;
                end else begin
                    args_exp_next = hdr_cnt;
                    arg_cnt_next  = '0;
                    exp_type_next = lookup_type(command_reg, 5'd0);
                    phase_next    = tcfp_pkg::PH_TAG;
                end
            end
            tcfp_pkg::PH_TAG:
            begin
                if (exp_type_reg > tcfp_pkg::TY_MAX || data_byte != {4'd0, exp_type_reg}) begin
                    err_next   = tcfp_pkg::ST_DECODE;
                    phase_next = tcfp_pkg::PH_SKIP;
                end else begin
                    acc_next = '0;
                    if (exp_type_reg == tcfp_pkg::TY_U8) begin
                        byte_cnt_next = 3'd1;
                        phase_next    = tcfp_pkg::PH_SCALAR;
                    end else if (exp_type_reg == tcfp_pkg::TY_U16) begin
                        byte_cnt_next = 3'd2;
                        phase_next    = tcfp_pkg::PH_SCALAR;
                    end else if (exp_type_reg == tcfp_pkg::TY_U32
                                 || exp_type_reg == tcfp_pkg::TY_INT) begin
                        byte_cnt_next = 3'd4;
                        phase_next    = tcfp_pkg::PH_SCALAR;
                    end else begin
                        phase_next = tcfp_pkg::PH_MODE;
                    end
                end
            end
            tcfp_pkg::PH_SCALAR:
            begin
                acc_next      = acc_shift;
                byte_cnt_next = byte_dec;
                if (byte_dec == 3'd0) begin
                    data_v        = 1'b1;
                    data_rec.kind = tcfp_pkg::KIND_SCALAR;
                    adv_arg       = 1'b1;
                end
            end
            tcfp_pkg::PH_MODE:
            begin
                acc_next = '0;
                if ((data_byte & tcfp_pkg::MODE_ARRAY) != 8'd0) begin
                    array_len_next = data_byte[6:0] & tcfp_pkg::MODE_LEN[6:0];
                    elem_cnt_next  = '0;
                    if (array_len_next == 7'd0) begin
                        adv_arg = 1'b1;
                    end else begin
                        byte_cnt_next = tcfp_pkg::elem_bytes(exp_type_reg);
                        phase_next    = tcfp_pkg::PH_ELEM;
                    end
                end else begin
                    byte_cnt_next = 3'd4;
                    phase_next    = tcfp_pkg::PH_ADDR;
                end
            end
            tcfp_pkg::PH_ELEM:
            begin
                acc_next      = acc_shift;
                byte_cnt_next = byte_dec;
                if (byte_dec == 3'd0) begin
                    data_v            = 1'b1;
                    data_rec.kind     = tcfp_pkg::KIND_ELEM;
                    data_rec.elem_idx = elem_cnt_reg;
                    elem_cnt_next     = elem_inc;
                    acc_next          = '0;
                    if (elem_inc >= array_len_reg) begin
                        adv_arg = 1'b1;
                    end else begin
                        byte_cnt_next = tcfp_pkg::elem_bytes(exp_type_reg);
                    end
                end
            end
            tcfp_pkg::PH_ADDR:
            begin
                acc_next      = acc_shift;
                byte_cnt_next = byte_dec;
                if (byte_dec == 3'd0) begin
                    data_v        = 1'b1;
                    data_rec.kind = tcfp_pkg::KIND_ADDR;
                    adv_arg       = 1'b1;
                end
            end
            tcfp_pkg::PH_SKIP:
            begin
                phase_next = tcfp_pkg::PH_SKIP;
            end
            default:
            begin
                phase_next = tcfp_pkg::PH_SKIP;
            end
        endcase

        // move on to the next argument or finish the argument list
        if (adv_arg) begin
            arg_cnt_next = arg_inc;
            if (arg_inc >= args_exp_reg) begin
                phase_next = tcfp_pkg::PH_SKIP;
            end else begin
                exp_type_next = lookup_type(command_reg, arg_inc);
                phase_next    = tcfp_pkg::PH_TAG;
            end
        end

        // frame status
        if (phase_reg == tcfp_pkg::PH_CMD) begin
            stat_code = tcfp_pkg::ST_SHORT;
        end else if (err_next != tcfp_pkg::ST_OK) begin
            stat_code = err_next;
        end else if (phase_next == tcfp_pkg::PH_SKIP) begin
            stat_code = tcfp_pkg::ST_OK;
        end else begin
            stat_code = tcfp_pkg::ST_DECODE;
        end
        stat_v           = frame_end;
        stat_rec         = '0;
        stat_rec.kind    = tcfp_pkg::KIND_STATUS;
        stat_rec.cmd     = command_next;
        stat_rec.arg_idx = arg_cnt_next;
        stat_rec.st      = stat_code;
        stat_rec.is_last = 1'b1;

        // frame end clears the frame, command stays
        if (frame_end) begin
            phase_next     = tcfp_pkg::PH_CMD;
            args_exp_next  = '0;
            arg_cnt_next   = '0;
            exp_type_next  = '0;
            byte_cnt_next  = '0;
            acc_next       = '0;
            array_len_next = '0;
            elem_cnt_next  = '0;
            err_next       = tcfp_pkg::ST_OK;
        end
    end

    // parse state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg     <= tcfp_pkg::PH_CMD;
            command_reg   <= '0;
            args_exp_reg  <= '0;
            arg_cnt_reg   <= '0;
            exp_type_reg  <= '0;
            byte_cnt_reg  <= '0;
            acc_reg       <= '0;
            array_len_reg <= '0;
            elem_cnt_reg  <= '0;
            err_reg       <= '0;
        end else if (item_fire) begin
            phase_reg     <= phase_next;
            command_reg   <= command_next;
            args_exp_reg  <= args_exp_next;
            arg_cnt_reg   <= arg_cnt_next;
            exp_type_reg  <= exp_type_next;
            byte_cnt_reg  <= byte_cnt_next;
            acc_reg       <= acc_next;
            array_len_reg <= array_len_next;
            elem_cnt_reg  <= elem_cnt_next;
            err_reg       <= err_next;
        end
    end

    // result queue control
    assign item_ready = (count_reg < 3'd3);
    assign push_n     = item_fire ? ({1'b0, data_v} + {1'b0, stat_v}) : 2'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + push_n;
            if (rec_fire) begin
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            end
            count_reg <= count_reg + {1'b0, push_n} - {2'd0, rec_fire};
        end
    end

    // result queue storage, data item first then status
    always_ff @(posedge clk)
    begin
        if (item_fire) begin
            if (data_v) begin
                queue_reg[wr_ptr_reg] <= data_rec;
                if (stat_v) begin
                    queue_reg[wr_ptr_reg + 2'd1] <= stat_rec;
                end
            end else if (stat_v) begin
                queue_reg[wr_ptr_reg] <= stat_rec;
            end
        end
    end

    // output fields from the queue head
    assign rec_valid     = (count_reg != 3'd0);
    assign record_kind   = queue_reg[rd_ptr_reg].kind;
    assign command_code  = queue_reg[rd_ptr_reg].cmd;
    assign arg_index     = queue_reg[rd_ptr_reg].arg_idx;
    assign arg_type      = queue_reg[rd_ptr_reg].arg_ty;
    assign value         = queue_reg[rd_ptr_reg].val;
    assign element_index = queue_reg[rd_ptr_reg].elem_idx;
    assign status        = queue_reg[rd_ptr_reg].st;
    assign last          = queue_reg[rd_ptr_reg].is_last;

    // checks
    `TCFP_ASSERT_NOW(a_queue_bound, 1'b1, count_reg <= 3'(QDEPTH),
        "result queue count beyond depth")
    `TCFP_ASSERT_NEXT(a_end_restarts, item_fire && frame_end, phase_reg == tcfp_pkg::PH_CMD,
        "frame end did not return to command phase")
    `TCFP_ASSERT_NOW(a_elem_range, phase_reg == tcfp_pkg::PH_ELEM,
        array_len_reg != 7'd0 && elem_cnt_reg < array_len_reg,
        "element counter outside array length")
    `TCFP_ASSERT_NOW(a_last_is_status, rec_valid && last,
        record_kind == tcfp_pkg::KIND_STATUS, "last set on a data item")
    `TCFP_ASSERT_NOW(a_data_clean, rec_valid && record_kind != tcfp_pkg::KIND_STATUS,
        status == tcfp_pkg::ST_OK && !last, "data item carries status fields")

endmodule

`default_nettype wire
